### rtl/tfs_pkg.sv
// tfs_pkg: shared constants and types for the circular scroll frame store
// item kind codes, scroll move codes, default geometry and memory command struct
// no dependencies
`default_nettype none

package tfs_pkg;

  // default geometry of the frame
  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  // fixed field widths
  localparam int KIND_W = 2;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int MOVE_W = 2;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // move codes, two's complement +1 and -1
  localparam logic [MOVE_W-1:0] MOVE_POS = 2'b01;
  localparam logic [MOVE_W-1:0] MOVE_NEG = 2'b11;

  // frame memory command
  typedef struct packed {
    logic we;
    logic re;
  } mem_cmd_t;

endpackage

`default_nettype wire

### rtl/tfs_frame_mem.sv
// tfs_frame_mem: single-port character store with registered read data
// one write or one read per cycle; contents undefined until written
// depends on tfs_pkg
`default_nettype none

module tfs_frame_mem #(
  parameter int DEPTH = tfs_pkg::ROWS_DEF * tfs_pkg::COLS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire tfs_pkg::mem_cmd_t           cmd,
  input  wire logic [AW-1:0]               addr,
  input  wire logic [tfs_pkg::CHAR_W-1:0]  wdata,
  output      logic [tfs_pkg::CHAR_W-1:0]  rdata
);
  import tfs_pkg::*;

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[addr] <= wdata;
    end
    if (cmd.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/text_frame_wraparound_scroll.sv
// text_frame_wraparound_scroll: ROWS x COLS character frame with circular scroll
// throughput: one word per cycle, but a read stalls while an earlier result is pending
// a read passes the input register, then the memory read register, to out_read_character
// reset: clears pipeline valids and both scroll offsets; the frame store is not cleared
// depends on tfs_pkg and tfs_frame_mem
`default_nettype none

module text_frame_wraparound_scroll #(
  parameter int ROWS = tfs_pkg::ROWS_DEF,
  parameter int COLS = tfs_pkg::COLS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic [tfs_pkg::KIND_W-1:0]         in_kind,
  input  wire logic [tfs_pkg::ROW_W-1:0]          in_row,
  input  wire logic [tfs_pkg::COL_W-1:0]          in_column,
  input  wire logic [tfs_pkg::CHAR_W-1:0]         in_character,
  input  wire logic signed [tfs_pkg::MOVE_W-1:0]  in_horizontal_move,
  input  wire logic signed [tfs_pkg::MOVE_W-1:0]  in_vertical_move,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic [tfs_pkg::CHAR_W-1:0]         out_read_character
);
  import tfs_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RSW   = ((RW > ROW_W) ? RW : ROW_W) + 1;
  localparam int CSW   = ((CW > COL_W) ? CW : COL_W) + 1;

  // input register
  logic              s1_valid_r, s1_valid_nxt;
  logic [KIND_W-1:0] s1_kind_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic [MOVE_W-1:0] s1_hmove_r;
  logic [MOVE_W-1:0] s1_vmove_r;

  // scroll offsets
  logic [RW-1:0] row_off_r, row_off_nxt;
  logic [CW-1:0] col_off_r, col_off_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  logic out_inside_r;

  logic s1_is_read, s1_adv, in_fire, pos_in_frame;
  logic [RSW-1:0] row_sum;
  logic [CSW-1:0] col_sum;
  logic [RW-1:0]  store_row;
  logic [CW-1:0]  store_col;
  logic [AW-1:0]  mem_addr;
  logic [CHAR_W-1:0] mem_rdata;
  mem_cmd_t mem_cmd;

  assign s1_is_read = (s1_kind_r == KIND_READ);
  // a read may only leave when the result register is free or being drained
  assign s1_adv   = s1_valid_r && (!s1_is_read || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  assign pos_in_frame = (32'(s1_row_r) < 32'(ROWS)) && (32'(s1_col_r) < 32'(COLS));

  // displayed position plus offset, wrapped with one compare and subtract
  always_comb begin
    row_sum = RSW'(s1_row_r) + RSW'(row_off_r);
    if (row_sum >= RSW'(ROWS)) begin
      row_sum = row_sum - RSW'(ROWS);
    end
    col_sum = CSW'(s1_col_r) + CSW'(col_off_r);
    if (col_sum >= CSW'(COLS)) begin
      col_sum = col_sum - CSW'(COLS);
    end
    store_row = row_sum[RW-1:0];
    store_col = col_sum[CW-1:0];
    mem_addr  = AW'(AW'(store_row) * AW'(COLS)) + AW'(store_col);
  end

  always_comb begin
    mem_cmd.we = s1_adv && (s1_kind_r == KIND_WRITE) && pos_in_frame;
    mem_cmd.re = s1_adv && s1_is_read;
  end

  // offset update on a scroll step
  always_comb begin
    row_off_nxt = row_off_r;
    col_off_nxt = col_off_r;
    if (s1_adv && (s1_kind_r == KIND_SCROLL)) begin
      // left shows the cell to the right: offset grows
      if (s1_hmove_r == MOVE_NEG) begin
        col_off_nxt = (col_off_r == CW'(COLS - 1)) ? '0 : col_off_r + CW'(1);
      end else if (s1_hmove_r == MOVE_POS) begin
        col_off_nxt = (col_off_r == '0) ? CW'(COLS - 1) : col_off_r - CW'(1);
      end
      if (s1_vmove_r == MOVE_POS) begin
        row_off_nxt = (row_off_r == RW'(ROWS - 1)) ? '0 : row_off_r + RW'(1);
      end else if (s1_vmove_r == MOVE_NEG) begin
        row_off_nxt = (row_off_r == '0) ? RW'(ROWS - 1) : row_off_r - RW'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_is_read) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      row_off_r   <= '0;
      col_off_r   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      row_off_r   <= row_off_nxt;
      col_off_r   <= col_off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r  <= in_kind;
      s1_row_r   <= in_row;
      s1_col_r   <= in_column;
      s1_char_r  <= in_character;
      s1_hmove_r <= in_horizontal_move;
      s1_vmove_r <= in_vertical_move;
    end
    if (s1_adv && s1_is_read) begin
      out_inside_r <= pos_in_frame;
    end
  end

  tfs_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (s1_char_r),
    .rdata (mem_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_read_character = out_inside_r ? mem_rdata : '0;

  a_row_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(row_off_r) < 32'(ROWS))
    else $error("row offset out of range");

  a_col_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_off_r) < 32'(COLS))
    else $error("column offset out of range");

  a_read_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_is_read) |=> out_valid)
    else $error("read word did not reach the result register");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(s1_adv && s1_is_read))
    else $error("pending result overwritten");

  a_one_mem_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_cmd.we && mem_cmd.re))
    else $error("write and read in the same cycle");

endmodule

`default_nettype wire
